>>> rtl/core/pspf_pkg.sv
// Package for the packed mono span fill block.
// Shared constants, register indexes and controller/datapath interface structs.
// No dependencies.
`default_nettype none

package pspf_pkg;

  localparam int SCREEN_MAX_BYTES = 8192;
  localparam int ROW_MAX_BYTES    = 64;

  localparam int XW     = 9;   // pixel column width
  localparam int ROWW   = 13;  // pixel row width
  localparam int ADDRW  = 13;  // byte address width
  localparam int BPRW   = 7;   // bytes_per_row register width
  localparam int SBW    = 14;  // screen_bytes register width
  localparam int BASEW  = BPRW + ROWW;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 14;

  localparam logic [BPRW-1:0]   BPR_RESET   = BPRW'(8);
  localparam logic [BPRW-1:0]   BPR_MAX     = BPRW'(ROW_MAX_BYTES);
  localparam logic [SBW-1:0]    SB_RESET    = SBW'(192);
  localparam logic [SBW-1:0]    BOUND_MAX   = SBW'(SCREEN_MAX_BYTES);
  localparam logic [7:0]        MASK_FULL   = 8'hFF;

  localparam logic [CFG_IW-1:0] REG_BYTES_PER_ROW = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_SCREEN_BYTES  = CFG_IW'(1);

  typedef struct packed {
    logic load;   // capture input item
    logic mul;    // register row base address
    logic eval;   // bound check and first result
    logic step;   // advance to next byte
  } dp_cmd_t;

  typedef struct packed {
    logic last;   // current result is the final one of the span
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/pspf_datapath.sv
// Datapath for the span fill: config registers, address math, result registers.
// Depends on pspf_pkg; driven by pspf_ctrl commands.
`default_nettype none

module pspf_datapath (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [pspf_pkg::CFG_IW-1:0]   cfg_index,
  input  wire [pspf_pkg::CFG_DW-1:0]   cfg_data,
  input  wire [pspf_pkg::XW-1:0]       x_start,
  input  wire [pspf_pkg::XW-1:0]       x_end,
  input  wire [pspf_pkg::ROWW-1:0]     row,
  input  pspf_pkg::dp_cmd_t            cmd,
  output pspf_pkg::dp_stat_t           stat,
  output logic [pspf_pkg::ADDRW-1:0]   byte_address,
  output logic [7:0]                   set_mask,
  output logic                         is_error,
  output logic                         last
);
  import pspf_pkg::*;

  logic [BPRW-1:0]  bytes_per_row;
  logic [SBW-1:0]   screen_bytes;
  logic [BPRW-1:0]  bpr_next;

  logic [5:0]       xs_hi, xe_hi;
  logic [2:0]       xs_lo, xe_lo;
  logic [ROWW-1:0]  row_q;
  logic [BASEW-1:0] base;

  logic [ADDRW-1:0] final_address;
  logic [7:0]       final_mask;

  logic [SBW-1:0]   bound;
  logic [BASEW-1:0] start_addr, end_addr;
  logic [7:0]       smask, emask;
  logic             span_err;
  logic [ADDRW-1:0] addr_inc;

  always_comb begin
    bpr_next = cfg_data[BPRW-1:0];
    if (bpr_next > BPR_MAX) begin
      bpr_next = BPR_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_row <= BPR_RESET;
      screen_bytes  <= SB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYTES_PER_ROW: bytes_per_row <= bpr_next;
        REG_SCREEN_BYTES:  screen_bytes  <= cfg_data[SBW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bound      = (screen_bytes > BOUND_MAX) ? BOUND_MAX : screen_bytes;
    start_addr = base + BASEW'(xs_hi);
    end_addr   = base + BASEW'(xe_hi);
    span_err   = (start_addr >= BASEW'(bound)) || (end_addr >= BASEW'(bound)) ||
                 (xs_hi > xe_hi);
    smask      = MASK_FULL >> xs_lo;
    emask      = ~(MASK_FULL >> ({1'b0, xe_lo} + 4'd1));
    addr_inc   = byte_address + ADDRW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_hi <= x_start[XW-1:3];
      xs_lo <= x_start[2:0];
      xe_hi <= x_end[XW-1:3];
      xe_lo <= x_end[2:0];
      row_q <= row;
    end
    if (cmd.mul) begin
      base <= BASEW'(bytes_per_row) * BASEW'(row_q);
    end
    if (cmd.eval) begin
      final_address <= end_addr[ADDRW-1:0];
      final_mask    <= emask;
      if (span_err) begin
        byte_address <= '0;
        set_mask     <= '0;
        is_error     <= 1'b1;
        last         <= 1'b1;
      end else if (xs_hi == xe_hi) begin
        byte_address <= start_addr[ADDRW-1:0];
        set_mask     <= smask & emask;
        is_error     <= 1'b0;
        last         <= 1'b1;
      end else begin
        byte_address <= start_addr[ADDRW-1:0];
        set_mask     <= smask;
        is_error     <= 1'b0;
        last         <= 1'b0;
      end
    end else if (cmd.step) begin
      byte_address <= addr_inc;
      if (addr_inc == final_address) begin
        set_mask <= final_mask;
        last     <= 1'b1;
      end else begin
        set_mask <= MASK_FULL;
        last     <= 1'b0;
      end
    end
  end

  assign stat.last = last;

endmodule

`default_nettype wire

>>> rtl/core/pspf_ctrl.sv
// Controller state machine for the span fill: handshakes and datapath commands.
// Depends on pspf_pkg.
`default_nettype none

module pspf_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  pspf_pkg::dp_stat_t  stat,
  output pspf_pkg::dp_cmd_t   cmd
);
  import pspf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL))
    else $error("accepted item did not start the sequence");
  a_eval_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |=> out_valid)
    else $error("no result after evaluation");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && stat.last) |=> in_ready)
    else $error("block not ready after final result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/packed_mono_span_fill_top.sv
// Top level of the packed mono span fill block.
// Instantiates pspf_ctrl and pspf_datapath; depends on pspf_pkg.
//
// Turns a horizontal span (x_start..x_end on one row) of a 1bpp MSB-first
// framebuffer into byte-address/OR-mask results, one per touched byte in
// ascending order, last set on the final one. A rejected span (address not
// below min(screen_bytes, 8192) or start byte after end byte) gives one
// result with is_error set. An item goes through setup (capture, row-base
// multiply, bound check) and then gives 1 to 64 results, one per cycle
// while out_ready is high; in_ready returns in the cycle after the final
// result is taken. Config writes are always ready and must be issued only
// while the block is idle.
`default_nettype none

module packed_mono_span_fill_top (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [pspf_pkg::CFG_IW-1:0]   cfg_index,
  input  wire [pspf_pkg::CFG_DW-1:0]   cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [pspf_pkg::XW-1:0]       x_start,
  input  wire [pspf_pkg::XW-1:0]       x_end,
  input  wire [pspf_pkg::ROWW-1:0]     row,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [pspf_pkg::ADDRW-1:0]   byte_address,
  output logic [7:0]                   set_mask,
  output logic                         is_error,
  output logic                         last
);
  import pspf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pspf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pspf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .x_start      (x_start),
    .x_end        (x_end),
    .row          (row),
    .cmd          (cmd),
    .stat         (stat),
    .byte_address (byte_address),
    .set_mask     (set_mask),
    .is_error     (is_error),
    .last         (last)
  );

endmodule

`default_nettype wire
